// ===== sv/u8bq_pkg.sv =====
// ----------------------------------------------------------------------------
// u8bq_pkg
// Shared types and byte-class constants for the bigram query tokenizer.
// ----------------------------------------------------------------------------
package u8bq_pkg;

    localparam logic [7:0] WORD_FLOOR = 8'h30;
    localparam logic [7:0] CONT_FLOOR = 8'h80;
    localparam logic [7:0] LEAD_FLOOR = 8'hE0;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    // one queued command: optional close, replay, new byte, final close
    typedef struct packed {
        logic       pre_end;
        logic       has_byte;
        logic       post_end;
        logic [7:0] data_byte;
    } cmd_ctrl_t;

    localparam int unsigned CTRL_W = $bits(cmd_ctrl_t);

endpackage

// ===== sv/u8bq_front.sv =====
// ----------------------------------------------------------------------------
// u8bq_front
// Classifies query bytes, tracks token mode and the latest wide character,
// and turns each byte into at most one queued command.
// ----------------------------------------------------------------------------
module u8bq_front #(
    parameter int unsigned MAX_CHAR_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_query,
    output logic                           push,
    output u8bq_pkg::cmd_ctrl_t            cmd_ctrl,
    output logic [MAX_CHAR_BYTES*8-1:0]    rep_bytes,
    output logic [$clog2(MAX_CHAR_BYTES+1)-1:0] rep_len
);
    import u8bq_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_CHAR_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_CHAR_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHAR_BYTES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_WIDE = 3'b100
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [1:0]       count_reg, count_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       char_reg [MAX_CHAR_BYTES];

    logic             is_word, is_lead, is_cont, is_sep;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             pre_end, has_byte, post_end;
    logic [LEN_W-1:0] rep_len_c;

    assign is_word = (data_byte > WORD_FLOOR) && (data_byte < CONT_FLOOR);
    assign is_lead = (data_byte >= LEAD_FLOOR);
    assign is_cont = (data_byte >= CONT_FLOOR) && (data_byte < LEAD_FLOOR);
    assign is_sep  = (data_byte == CHAR_SPACE) || (data_byte == CHAR_NL);

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        wr_idx     = '0;
        pre_end    = 1'b0;
        has_byte   = 1'b0;
        post_end   = 1'b0;
        rep_len_c  = '0;
        unique case (mode_reg)
            MODE_WORD:
            begin
                if (is_word)
                begin
                    has_byte = 1'b1;
                end
                else if (is_lead)
                begin
                    pre_end    = 1'b1;
                    has_byte   = 1'b1;
                    mode_next  = MODE_WIDE;
                    count_next = 2'd1;
                    wr_en      = 1'b1;
                    len_next   = LEN_ONE;
                end
                else if (is_sep)
                begin
                    pre_end    = 1'b1;
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    len_next   = '0;
                end
            end
            MODE_WIDE:
            begin
                if (is_sep)
                begin
                    pre_end    = 1'b1;
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    len_next   = '0;
                end
                else if (is_cont)
                begin
                    has_byte = 1'b1;
                    if (len_reg < LEN_MAX)
                    begin
                        wr_en    = 1'b1;
                        wr_idx   = len_reg[IDX_W-1:0];
                        len_next = len_reg + LEN_ONE;
                    end
                end
                else if (is_lead)
                begin
                    if (count_reg >= 2'd2)
                    begin
                        pre_end   = 1'b1;
                        rep_len_c = len_reg;
                    end
                    has_byte   = 1'b1;
                    count_next = 2'd2;
                    wr_en      = 1'b1;
                    len_next   = LEN_ONE;
                end
                else if (is_word)
                begin
                    pre_end    = 1'b1;
                    has_byte   = 1'b1;
                    mode_next  = MODE_WORD;
                    count_next = '0;
                    len_next   = '0;
                end
            end
            default:
            begin
                if (is_word)
                begin
                    has_byte   = 1'b1;
                    mode_next  = MODE_WORD;
                    count_next = '0;
                end
                else if (is_lead)
                begin
                    has_byte   = 1'b1;
                    mode_next  = MODE_WIDE;
                    count_next = 2'd1;
                    wr_en      = 1'b1;
                    len_next   = LEN_ONE;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
        endcase
        if (end_of_query)
        begin
            post_end   = (mode_next == MODE_WORD) || (mode_next == MODE_WIDE);
            mode_next  = MODE_IDLE;
            count_next = '0;
            len_next   = '0;
        end
    end

    assign push               = take && (pre_end || has_byte || post_end);
    assign cmd_ctrl.pre_end   = pre_end;
    assign cmd_ctrl.has_byte  = has_byte;
    assign cmd_ctrl.post_end  = post_end;
    assign cmd_ctrl.data_byte = data_byte;
    assign rep_len            = rep_len_c;

    for (genvar g = 0; g < MAX_CHAR_BYTES; g++)
    begin : g_rep
        assign rep_bytes[g*8 +: 8] = char_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_CHAR_BYTES; i++)
        begin
            if (take && wr_en && (wr_idx == IDX_W'(i)))
            begin
                char_reg[i] <= data_byte;
            end
        end
    end

endmodule

// ===== sv/u8bq_queue.sv =====
// ----------------------------------------------------------------------------
// u8bq_queue
// Small first-in first-out command queue between classifier and emitter.
// ----------------------------------------------------------------------------
module u8bq_queue #(
    parameter int unsigned DATA_W = 46
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head
);
    import u8bq_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W:0] CNT_DEPTH = (PTR_W+1)'(DEPTH);
    localparam logic [PTR_W:0] CNT_ONE   = (PTR_W+1)'(1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == CNT_DEPTH);
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/u8bq_back.sv =====
// ----------------------------------------------------------------------------
// u8bq_back
// Expands queued commands into result beats through an output register, one
// per cycle unless m_axis_tready stalls the output.
// ----------------------------------------------------------------------------
module u8bq_back #(
    parameter int unsigned MAX_CHAR_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  u8bq_pkg::cmd_ctrl_t            q_ctrl,
    input  logic [MAX_CHAR_BYTES*8-1:0]    q_rep_bytes,
    input  logic [$clog2(MAX_CHAR_BYTES+1)-1:0] q_rep_len,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import u8bq_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_CHAR_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_CHAR_BYTES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    cmd_ctrl_t                   ctrl_reg, ctrl_next;
    logic [MAX_CHAR_BYTES*8-1:0] rep_reg;
    logic [LEN_W-1:0]            len_reg, idx_reg, idx_next;

    logic                        valid_reg, last_reg, end_reg;
    logic [7:0]                  byte_reg;

    cmd_ctrl_t                   w_ctrl;
    logic [MAX_CHAR_BYTES*8-1:0] w_rep;
    logic [LEN_W-1:0]            w_len, w_idx;
    logic [7:0]                  rep_arr [MAX_CHAR_BYTES];
    logic                        use_q, have, out_ok, fire;
    logic [7:0]                  beat_byte;
    logic                        beat_end, beat_last;

    for (genvar g = 0; g < MAX_CHAR_BYTES; g++)
    begin : g_arr
        assign rep_arr[g] = w_rep[g*8 +: 8];
    end

    assign use_q  = !(ctrl_reg.pre_end || ctrl_reg.has_byte || ctrl_reg.post_end ||
                      (idx_reg < len_reg));
    assign w_ctrl = use_q ? q_ctrl : ctrl_reg;
    assign w_rep  = use_q ? q_rep_bytes : rep_reg;
    assign w_len  = use_q ? q_rep_len : len_reg;
    assign w_idx  = use_q ? '0 : idx_reg;
    assign have   = use_q ? q_valid : 1'b1;
    assign out_ok = !valid_reg || m_axis_tready;
    assign fire   = have && out_ok;
    assign q_pop  = use_q && q_valid && out_ok;

    always_comb
    begin
        ctrl_next = w_ctrl;
        idx_next  = w_idx;
        beat_byte = '0;
        beat_end  = 1'b0;
        priority if (w_ctrl.pre_end)
        begin
            beat_end          = 1'b1;
            ctrl_next.pre_end = 1'b0;
        end
        else if (w_idx < w_len)
        begin
            beat_byte = rep_arr[w_idx[IDX_W-1:0]];
            idx_next  = w_idx + LEN_ONE;
        end
        else if (w_ctrl.has_byte)
        begin
            beat_byte          = w_ctrl.data_byte;
            ctrl_next.has_byte = 1'b0;
        end
        else
        begin
            beat_end           = 1'b1;
            ctrl_next.post_end = 1'b0;
        end
        beat_last = !(ctrl_next.pre_end || ctrl_next.has_byte || ctrl_next.post_end ||
                      (idx_next < w_len));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ctrl_reg <= ctrl_next;
                len_reg  <= w_len;
                idx_reg  <= idx_next;
            end
            if (out_ok)
            begin
                valid_reg <= have;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rep_reg  <= w_rep;
            byte_reg <= beat_byte;
            end_reg  <= beat_end;
            last_reg <= beat_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = end_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ===== sv/utf8_bigram_query_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_bigram_query_tokenizer_unit
// Splits query bytes into word tokens and overlapping wide-character bigram
// tokens, emitted as byte beats closed by end-marker beats.
//
//   port group   dir  tdata               tuser      tlast
//   s_axis       in   data_byte [7:0]     -          end_of_query
//   m_axis       out  out_byte [7:0]      token_end  run_last
//
// one input beat a cycle while the four-entry command queue has room
// the emitter sends one result beat a cycle unless m_axis_tready stalls it, up to MAX_CHAR_BYTES+3 per input
// an input beat passes through the command queue and the output register before its first result beat
// rst_n clears mode, counters, queue and output valid; no clearing pass
// output stalls back up through the queue to s_axis_tready
// ----------------------------------------------------------------------------
module utf8_bigram_query_tokenizer_unit #(
    parameter int unsigned MAX_CHAR_BYTES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] token_end
    output logic       m_axis_tlast
);
    import u8bq_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_CHAR_BYTES + 1);
    localparam int unsigned REP_W = MAX_CHAR_BYTES * 8;
    localparam int unsigned Q_W   = CTRL_W + REP_W + LEN_W;

    logic                 take, push, q_full, q_valid, q_pop;
    cmd_ctrl_t            f_ctrl, q_ctrl;
    logic [REP_W-1:0]     f_rep, q_rep;
    logic [LEN_W-1:0]     f_len, q_len;
    logic [Q_W-1:0]       q_head;

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && !q_full;

    u8bq_front #(
        .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .data_byte    (s_axis_tdata),
        .end_of_query (s_axis_tlast),
        .push         (push),
        .cmd_ctrl     (f_ctrl),
        .rep_bytes    (f_rep),
        .rep_len      (f_len)
    );

    u8bq_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_ctrl, f_rep, f_len}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign q_ctrl = q_head[Q_W-1 -: CTRL_W];
    assign q_rep  = q_head[LEN_W +: REP_W];
    assign q_len  = q_head[LEN_W-1:0];

    u8bq_back #(
        .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ctrl        (q_ctrl),
        .q_rep_bytes   (q_rep),
        .q_rep_len     (q_len),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // end-marker beats carry no byte
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00))
        else $error("end marker beat with nonzero byte");

    // queued work with a free output always yields a beat next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && m_axis_tready) |=> m_axis_tvalid)
        else $error("emitter idle while commands wait");

    // input stalls only on a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_full)
        else $error("input stalled without full queue");
`endif

endmodule

// ===== tb/tb_utf8_bigram_query_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_bigram_query_tokenizer_unit
// Streams query bytes into the tokenizer and checks every result beat
// against an in-bench tokenizer model kept in step with accepted input beats.
// A directed opener covers byte classes, bigram replay and end of query;
// random queries of word, wide-character, separator and noise bytes follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_utf8_bigram_query_tokenizer_unit;

    import u8bq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int CHAR_BYTES_MAX = 4;
    localparam int TOTAL_ITEMS    = 350;
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 20;

    localparam int RCV_OPEN    = 0;
    localparam int RCV_RANDOM  = 1;
    localparam int RCV_PATTERN = 2;
    localparam int RCV_SPARSE  = 3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_WIDE = 2'd2
    } tok_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eoq;
        logic       drain_first;
    } query_byte_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_end;
        logic       run_last;
    } token_beat_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    query_byte_t query_q[$];
    token_beat_t token_beats_q[$];

    tok_mode_t   tok_mode      = MODE_IDLE;
    logic [1:0]  wide_cnt      = 2'd0;
    logic [7:0]  char_bytes [CHAR_BYTES_MAX];
    logic [2:0]  char_len      = 3'd0;

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    logic        timed_out      = 1'b0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          sent_count     = 0;
    int          rcv_cycle      = 0;
    int          rcv_style      = RCV_OPEN;

    utf8_bigram_query_tokenizer_unit #(
        .MAX_CHAR_BYTES (CHAR_BYTES_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic add_query_byte(input logic [7:0] b, input logic eoq, input logic drain);
        query_byte_t item;
        item.data_byte   = b;
        item.eoq         = eoq;
        item.drain_first = drain;
        query_q.insert(query_q.size(), item);
    endtask

    task automatic push_token_beat(input logic [7:0] b, input logic is_end);
        token_beat_t beat;
        beat.out_byte  = is_end ? 8'h00 : b;
        beat.token_end = is_end;
        beat.run_last  = 1'b0;
        token_beats_q.insert(token_beats_q.size(), beat);
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic eoq);
        logic        is_word;
        logic        is_lead;
        logic        is_cont;
        logic        is_sep;
        int          first;
        token_beat_t last_beat;
        is_word = (b > WORD_FLOOR) && (b < CONT_FLOOR);
        is_lead = (b >= LEAD_FLOOR);
        is_cont = (b >= CONT_FLOOR) && (b < LEAD_FLOOR);
        is_sep  = (b == CHAR_SPACE) || (b == CHAR_NL);
        first   = token_beats_q.size();
        case (tok_mode)
            MODE_WORD:
            begin
                if (is_word)
                begin
                    push_token_beat(b, 1'b0);
                end
                else if (is_lead)
                begin
                    push_token_beat(8'h00, 1'b1);
                    push_token_beat(b, 1'b0);
                    tok_mode      = MODE_WIDE;
                    wide_cnt      = 2'd1;
                    char_bytes[0] = b;
                    char_len      = 3'd1;
                end
                else if (is_sep)
                begin
                    push_token_beat(8'h00, 1'b1);
                    tok_mode = MODE_IDLE;
                    wide_cnt = 2'd0;
                    char_len = 3'd0;
                end
            end
            MODE_WIDE:
            begin
                if (is_sep)
                begin
                    push_token_beat(8'h00, 1'b1);
                    tok_mode = MODE_IDLE;
                    wide_cnt = 2'd0;
                    char_len = 3'd0;
                end
                else if (is_cont)
                begin
                    push_token_beat(b, 1'b0);
                    if (char_len < CHAR_BYTES_MAX)
                    begin
                        char_bytes[char_len[1:0]] = b;
                        char_len                  = char_len + 3'd1;
                    end
                end
                else if (is_lead)
                begin
                    // third and later wide chars: close and replay the previous one
                    if (wide_cnt >= 2'd2)
                    begin
                        push_token_beat(8'h00, 1'b1);
                        for (int i = 0; i < char_len; i++)
                            push_token_beat(char_bytes[i], 1'b0);
                    end
                    push_token_beat(b, 1'b0);
                    wide_cnt      = 2'd2;
                    char_bytes[0] = b;
                    char_len      = 3'd1;
                end
                else if (is_word)
                begin
                    push_token_beat(8'h00, 1'b1);
                    push_token_beat(b, 1'b0);
                    tok_mode = MODE_WORD;
                    wide_cnt = 2'd0;
                    char_len = 3'd0;
                end
            end
            default:
            begin
                if (is_word)
                begin
                    push_token_beat(b, 1'b0);
                    tok_mode = MODE_WORD;
                    wide_cnt = 2'd0;
                end
                else if (is_lead)
                begin
                    push_token_beat(b, 1'b0);
                    tok_mode      = MODE_WIDE;
                    wide_cnt      = 2'd1;
                    char_bytes[0] = b;
                    char_len      = 3'd1;
                end
                else
                begin
                    tok_mode = MODE_IDLE;
                end
            end
        endcase
        if (eoq)
        begin
            if (tok_mode == MODE_WORD || tok_mode == MODE_WIDE)
                push_token_beat(8'h00, 1'b1);
            tok_mode = MODE_IDLE;
            wide_cnt = 2'd0;
            char_len = 3'd0;
        end
        if (token_beats_q.size() > first)
        begin
            last_beat          = token_beats_q.pop_back();
            last_beat.run_last = 1'b1;
            token_beats_q.insert(token_beats_q.size(), last_beat);
        end
    endtask

    // sender: bursts with random gaps, optional hold until results drain
    always @(posedge clk)
    begin : drv_proc
        query_byte_t nxt;
        logic        drive_valid;
        if (rst_n)
        begin
            drive_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                tokenize_byte(s_axis_tdata, s_axis_tlast);
                drive_valid = 1'b0;
            end
            if (!drive_valid && query_q.size() > 0 &&
                !(query_q[0].drain_first && token_beats_q.size() > 0))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else
                begin
                    nxt = query_q.pop_front();
                    s_axis_tdata <= nxt.data_byte;
                    s_axis_tlast <= nxt.eoq;
                    drive_valid = 1'b1;
                    sent_count++;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        // stretches with no gaps at all
                        if ((sent_count / 64) % 3 == 1 || $urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 8);
                    end
                end
            end
            if (!drive_valid)
            begin
                s_axis_tdata <= 8'($urandom_range(0, 255));
                s_axis_tlast <= 1'($urandom_range(0, 1));
            end
            s_axis_tvalid <= drive_valid;
        end
    end

    // receiver stall pattern, style picked at random from four
    always @(posedge clk)
    begin : rcv_proc
        if (rst_n)
        begin
            rcv_cycle++;
            if (rcv_cycle % 96 == 0)
                rcv_style = $urandom_range(RCV_OPEN, RCV_SPARSE);
            case (rcv_style)
                RCV_OPEN:    m_axis_tready <= 1'b1;
                RCV_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RCV_PATTERN: m_axis_tready <= ((rcv_cycle % 7) >= 4);
                default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : mon_proc
        token_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (token_beats_q.size() == 0)
            begin
                report_mismatch("result beat with none expected", m_axis_tdata, 0);
            end
            else
            begin
                want = token_beats_q.pop_front();
                if (m_axis_tdata !== want.out_byte)
                    report_mismatch("out_byte", m_axis_tdata, want.out_byte);
                if (m_axis_tuser !== want.token_end)
                    report_mismatch("token_end", m_axis_tuser, want.token_end);
                if (m_axis_tlast !== want.run_last)
                    report_mismatch("run_last", m_axis_tlast, want.run_last);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
                timed_out <= 1'b1;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : main_proc
        query_byte_t last_item;
        int          pieces;
        int          kind;
        int          cnt;
        int          chars;
        logic        drain_next;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < CHAR_BYTES_MAX; i++)
            char_bytes[i] = 8'h00;

        // separators and control bytes when idle, word extremes, digit zero
        add_query_byte(CHAR_SPACE, 1'b0, 1'b0);
        add_query_byte(CHAR_NL, 1'b0, 1'b0);
        add_query_byte(8'h00, 1'b0, 1'b0);
        add_query_byte(8'h31, 1'b0, 1'b0);
        add_query_byte(8'h30, 1'b0, 1'b0);
        add_query_byte(8'h7F, 1'b0, 1'b0);
        add_query_byte(8'h80, 1'b0, 1'b0);
        // lead after word, overlong char, control in wide token
        add_query_byte(8'hE0, 1'b0, 1'b0);
        add_query_byte(8'h80, 1'b0, 1'b0);
        add_query_byte(8'hBF, 1'b0, 1'b0);
        add_query_byte(8'hC0, 1'b0, 1'b0);
        add_query_byte(8'hDF, 1'b0, 1'b0);
        add_query_byte(8'hE5, 1'b0, 1'b0);
        add_query_byte(8'h09, 1'b0, 1'b0);
        // third wide char replays the previous one
        add_query_byte(8'hFF, 1'b0, 1'b0);
        add_query_byte(8'hA5, 1'b0, 1'b0);
        add_query_byte(8'hE1, 1'b0, 1'b0);
        add_query_byte(8'h41, 1'b0, 1'b0);
        add_query_byte(CHAR_NL, 1'b0, 1'b0);
        add_query_byte(8'hF0, 1'b0, 1'b0);
        add_query_byte(8'h9F, 1'b0, 1'b0);
        add_query_byte(CHAR_SPACE, 1'b0, 1'b0);
        // end of query with wide, word and no token open
        add_query_byte(8'hEA, 1'b0, 1'b0);
        add_query_byte(8'hB0, 1'b1, 1'b0);
        add_query_byte(8'h42, 1'b1, 1'b0);
        add_query_byte(8'h05, 1'b1, 1'b0);
        add_query_byte(8'h99, 1'b0, 1'b0);

        drain_next = 1'b1;
        while (query_q.size() < TOTAL_ITEMS)
        begin
            pieces = $urandom_range(1, 10);
            for (int p = 0; p < pieces; p++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 4)
                begin
                    chars = $urandom_range(1, 4);
                    for (int c = 0; c < chars; c++)
                    begin
                        add_query_byte(8'($urandom_range(8'hE0, 8'hFF)), 1'b0, drain_next);
                        drain_next = 1'b0;
                        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6)
                                                          : $urandom_range(0, 3);
                        for (int k = 0; k < cnt; k++)
                        begin
                            if ($urandom_range(0, 5) == 0)
                                add_query_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0, 1'b0);
                            else
                                add_query_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b0);
                        end
                    end
                end
                else if (kind < 7)
                begin
                    cnt = $urandom_range(1, 6);
                    for (int k = 0; k < cnt; k++)
                    begin
                        add_query_byte(8'($urandom_range(8'h31, 8'h7F)), 1'b0, drain_next);
                        drain_next = 1'b0;
                    end
                end
                else if (kind < 9)
                begin
                    add_query_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NL, 1'b0,
                                   drain_next);
                    drain_next = 1'b0;
                end
                else
                begin
                    add_query_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   drain_next);
                    drain_next = 1'b0;
                end
            end
            if ($urandom_range(0, 4) != 0)
            begin
                last_item     = query_q.pop_back();
                last_item.eoq = 1'b1;
                query_q.insert(query_q.size(), last_item);
            end
            drain_next = ($urandom_range(0, 9) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out &&
               (query_q.size() > 0 || s_axis_tvalid || token_beats_q.size() > 0))
            @(posedge clk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);

        if (!timed_out && mismatch_count == 0 && token_beats_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== utf8_bigram_query_tokenizer_unit.f =====
sv/u8bq_pkg.sv
sv/u8bq_front.sv
sv/u8bq_queue.sv
sv/u8bq_back.sv
sv/utf8_bigram_query_tokenizer_unit.sv
tb/tb_utf8_bigram_query_tokenizer_unit.sv
